// ===== rtl/dcos_pkg.sv =====
package dcos_pkg;

   // default store geometry
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 512;

   // result queue depth (power of two)
   localparam int RSP_DEPTH   = 16;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = RSP_PTR_W + 1;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OCC_ENABLE   = 3'd0,
      REG_SHADOW_DIST  = 3'd1,
      REG_SHADOW_TMO   = 3'd2,
      REG_CENTER_X     = 3'd3,
      REG_CENTER_Y     = 3'd4,
      REG_INV_FOCAL_X  = 3'd5,
      REG_INV_FOCAL_Y  = 3'd6,
      REG_IMAGE_WIDTH  = 3'd7
   } csr_reg_type;

   // one shadow store entry; depth 0 means empty
   typedef struct packed {
      logic [15:0] depth;
      logic [31:0] stamp;
      logic [23:0] x;
      logic [23:0] y;
      logic [23:0] rgb;
   } entry_type;

   // one result word
   typedef struct packed {
      logic [23:0] x;
      logic [23:0] y;
      logic [15:0] z;
      logic [23:0] color;
      logic        is_shadow;
      logic        last;
   } point_type;

   // truncated magnitude to signed 24-bit with clamp
   function automatic logic [23:0] sat_coord(input logic neg, input logic [27:0] q);
      logic [23:0] r;
      if (neg) begin
         if (q > 28'd8388608) r = 24'h800000;
         else                 r = 24'(~q[23:0] + 24'd1);
      end else begin
         if (q > 28'd8388607) r = 24'h7FFFFF;
         else                 r = q[23:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/dcos_store.sv =====
module dcos_store #(
   parameter int SIZE = 524288,
   parameter int AW   = 19
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear_req,
   output logic                clearing,
   input  logic [AW-1:0]       rd_addr,
   output dcos_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  dcos_pkg::entry_type wr_data
);
   import dcos_pkg::*;

   entry_type     mem [SIZE];
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   entry_type     rd_ff;

   // clearing sweep: one entry per cycle
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clear_req) begin
         clr_in     = 1'b1;
         clr_cnt_in = '0;
      end else if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(SIZE - 1)) clr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (clr_ff) mem[clr_cnt_ff] <= '0;
      else if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_ff;
   assign clearing = clr_ff;

endmodule

// ===== rtl/dcos_rsp_fifo.sv =====
module dcos_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          push_n,
   input  dcos_pkg::point_type                 push_a,
   input  dcos_pkg::point_type                 push_b,
   output logic [dcos_pkg::RSP_CNT_W-1:0]      count,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dcos_pkg::point_type                 head
);
   import dcos_pkg::*;

   point_type              slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wp_ff, rp_ff;
   logic [RSP_CNT_W-1:0]   cnt_ff;
   logic                   pop;

   assign pop = (cnt_ff != '0) && !rsp_stall;

   // up to two words in, one out
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_ff + RSP_PTR_W'(push_n);
         rp_ff  <= rp_ff + RSP_PTR_W'(pop);
         cnt_ff <= cnt_ff + RSP_CNT_W'(push_n) - RSP_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) slot_ff[wp_ff] <= push_a;
      if (push_n == 2'd2) slot_ff[wp_ff + RSP_PTR_W'(1)] <= push_b;
   end

   assign count     = cnt_ff;
   assign rsp_valid = cnt_ff != '0;
   assign head      = slot_ff[rp_ff];

endmodule

// ===== rtl/depth_cloud_occlusion_shadow.sv =====
// Depth pixel to 3-D point back-projection with an occlusion shadow store.
// Request channel (req_*): one depth pixel per word, accepted when req_valid
// is high and req_stall low. Response channel (rsp_*): points, one per word,
// in pixel order; rsp_last marks the final point of a pixel (a pixel gives
// zero, one or two points). Configuration (csr_*) is a plain write port that
// the user must use only while the block is idle; it does not enforce this.
// Pipeline: stage 0 forms the store address and offsets and issues the store
// read, stage 1 does the first multiply and picks up the entry (forwarded
// from the two most recent writes), stage 2 does the depth multiply, expiry
// and shadow decision, writes back and pushes into a 16-word result queue.
// rsp_valid rises once an accepted pixel has passed the stage 0, 1 and 2
// registers and been written into the result queue. A pixel can be taken
// every cycle while req_stall is low; sustained rate is set by the single
// response port, one point per cycle while rsp_stall is low.
// req_stall rises when the queue cannot hold the worst case of what is in
// flight; a stalled receiver thus fills the queue and then stops requests.
// Reset and every write of occlusion_enable (or a changed image_width) start
// a clearing pass over all MAX_WIDTH*MAX_HEIGHT store entries (524288 by
// default), during which req_stall is high.
module depth_cloud_occlusion_shadow #(
   parameter int MAX_WIDTH  = dcos_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dcos_pkg::MAX_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [dcos_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dcos_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [9:0]                         req_column,
   input  logic [8:0]                         req_row,
   input  logic [15:0]                        req_depth_mm,
   input  logic [23:0]                        req_pixel_color,
   input  logic                               req_has_color,
   input  logic [31:0]                        req_frame_time,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [23:0]                 rsp_x_mm,
   output logic signed [23:0]                 rsp_y_mm,
   output logic [15:0]                        rsp_z_mm,
   output logic [23:0]                        rsp_point_color,
   output logic                               rsp_is_shadow,
   output logic                               rsp_last
);
   import dcos_pkg::*;

   localparam int SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW   = $clog2(SIZE);

   // configuration registers
   logic        occ_en_ff;
   logic [15:0] dist_ff, cx_ff, cy_ff;
   logic [31:0] tmo_ff;
   logic [23:0] ifx_ff, ify_ff;
   logic [10:0] width_ff;
   logic        clear_req;

   always_comb begin
      clear_req = 1'b0;
      if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_OCC_ENABLE:  clear_req = 1'b1;
            REG_IMAGE_WIDTH: clear_req = csr_data[10:0] != width_ff;
            default:         clear_req = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_en_ff <= 1'b0;
         dist_ff   <= 16'd0;
         tmo_ff    <= 32'd1000;
         cx_ff     <= 16'd5120;
         cy_ff     <= 16'd3840;
         ifx_ff    <= 24'd32000;
         ify_ff    <= 24'd32000;
         width_ff  <= 11'd640;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_OCC_ENABLE:  occ_en_ff <= csr_data[0];
            REG_SHADOW_DIST: dist_ff   <= csr_data[15:0];
            REG_SHADOW_TMO:  tmo_ff    <= csr_data;
            REG_CENTER_X:    cx_ff     <= csr_data[15:0];
            REG_CENTER_Y:    cy_ff     <= csr_data[15:0];
            REG_INV_FOCAL_X: ifx_ff    <= csr_data[23:0];
            REG_INV_FOCAL_Y: ify_ff    <= csr_data[23:0];
            REG_IMAGE_WIDTH: width_ff  <= csr_data[10:0];
            default:         ;
         endcase
      end
   end

   // ---------------- stage 0 ----------------
   logic        s0_v_ff;
   logic [9:0]  s0_col_ff;
   logic [8:0]  s0_row_ff;
   logic [15:0] s0_depth_ff;
   logic [23:0] s0_rgb_ff;
   logic [31:0] s0_now_ff;

   logic        clearing;
   logic [RSP_CNT_W-1:0] q_count;
   logic [RSP_CNT_W+2:0] need;
   logic        accept;

   // reserve queue room for the worst case of everything in flight
   logic s1_v_ff, s2_v_ff;
   assign need = (RSP_CNT_W+3)'(q_count)
               + (RSP_CNT_W+3)'({s0_v_ff, 1'b0})
               + (RSP_CNT_W+3)'({s1_v_ff, 1'b0})
               + (RSP_CNT_W+3)'({s2_v_ff, 1'b0})
               + (RSP_CNT_W+3)'(2);
   assign req_stall = clearing || (need > (RSP_CNT_W+3)'(RSP_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) s0_v_ff <= 1'b0;
      else       s0_v_ff <= accept;
      if (accept) begin
         s0_col_ff   <= req_column;
         s0_row_ff   <= req_row;
         s0_depth_ff <= req_depth_mm;
         s0_rgb_ff   <= req_has_color ? req_pixel_color : 24'hFFFFFF;
         s0_now_ff   <= req_frame_time;
      end
   end

   logic [31:0] addr_full;
   logic        use0;
   logic [15:0] p16x, p16y, magx, magy;
   logic        negx, negy;

   always_comb begin
      addr_full = 32'(s0_row_ff) * 32'(width_ff) + 32'(s0_col_ff);
      use0 = occ_en_ff && (11'(s0_col_ff) < width_ff) && (addr_full < 32'(SIZE));
      p16x = {2'b00, s0_col_ff, 4'b0000};
      p16y = {3'b000, s0_row_ff, 4'b0000};
      negx = p16x < cx_ff;
      negy = p16y < cy_ff;
      magx = negx ? cx_ff - p16x : p16x - cx_ff;
      magy = negy ? cy_ff - p16y : p16y - cy_ff;
   end

   // ---------------- stage 1 ----------------
   logic          s1_use_ff, s1_negx_ff, s1_negy_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [15:0]   s1_depth_ff, s1_magx_ff, s1_magy_ff;
   logic [23:0]   s1_rgb_ff;
   logic [31:0]   s1_now_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else       s1_v_ff <= s0_v_ff;
      s1_use_ff   <= use0;
      s1_addr_ff  <= addr_full[AW-1:0];
      s1_depth_ff <= s0_depth_ff;
      s1_rgb_ff   <= s0_rgb_ff;
      s1_now_ff   <= s0_now_ff;
      s1_negx_ff  <= negx;
      s1_negy_ff  <= negy;
      s1_magx_ff  <= magx;
      s1_magy_ff  <= magy;
   end

   entry_type     rd_data, wdata, ent_sel;
   logic          wr_en;
   logic          lw_v_ff;
   logic [AW-1:0] lw_addr_ff;
   entry_type     lw_data_ff;
   logic [AW-1:0] s2_addr_ff;

   // forward writes the store read could not see yet
   always_comb begin
      if (wr_en && s2_addr_ff == s1_addr_ff)          ent_sel = wdata;
      else if (lw_v_ff && lw_addr_ff == s1_addr_ff)   ent_sel = lw_data_ff;
      else                                            ent_sel = rd_data;
   end

   // ---------------- stage 2 ----------------
   logic          s2_use_ff, s2_negx_ff, s2_negy_ff;
   logic [15:0]   s2_depth_ff;
   logic [23:0]   s2_rgb_ff;
   logic [31:0]   s2_now_ff;
   logic [39:0]   s2_p1x_ff, s2_p1y_ff;
   entry_type     s2_ent_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else       s2_v_ff <= s1_v_ff;
      s2_use_ff   <= s1_use_ff;
      s2_addr_ff  <= s1_addr_ff;
      s2_depth_ff <= s1_depth_ff;
      s2_rgb_ff   <= s1_rgb_ff;
      s2_now_ff   <= s1_now_ff;
      s2_negx_ff  <= s1_negx_ff;
      s2_negy_ff  <= s1_negy_ff;
      s2_p1x_ff   <= 40'(s1_magx_ff) * 40'(ifx_ff);
      s2_p1y_ff   <= 40'(s1_magy_ff) * 40'(ify_ff);
      s2_ent_ff   <= ent_sel;
   end

   logic [55:0] p2x, p2y;
   logic [23:0] cur_x, cur_y;
   logic        live, expired, sd_live, near, fresh;
   logic [31:0] age;
   logic [1:0]  push_n;
   point_type   cur_pt, shd_pt, push_a, push_b;

   always_comb begin
      p2x   = 56'(s2_p1x_ff) * 56'(s2_depth_ff);
      p2y   = 56'(s2_p1y_ff) * 56'(s2_depth_ff);
      cur_x = sat_coord(s2_negx_ff, p2x[55:28]);
      cur_y = sat_coord(s2_negy_ff, p2y[55:28]);
      age     = s2_now_ff - s2_ent_ff.stamp;
      live    = s2_ent_ff.depth != 16'd0;
      expired = live && (age > tmo_ff);
      sd_live = live && !expired;
      near    = sd_live && ((17'(s2_depth_ff) + 17'(dist_ff)) < 17'(s2_ent_ff.depth));
      fresh   = s2_depth_ff != 16'd0;

      cur_pt = '{x: cur_x, y: cur_y, z: s2_depth_ff, color: s2_rgb_ff,
                 is_shadow: 1'b0, last: 1'b1};
      shd_pt = '{x: s2_ent_ff.x, y: s2_ent_ff.y, z: s2_ent_ff.depth,
                 color: s2_ent_ff.rgb, is_shadow: 1'b1, last: 1'b1};

      push_n = 2'd0;
      push_a = cur_pt;
      push_b = shd_pt;
      wr_en  = 1'b0;
      wdata  = '{depth: 16'd0, stamp: s2_ent_ff.stamp, x: s2_ent_ff.x,
                 y: s2_ent_ff.y, rgb: s2_ent_ff.rgb};
      if (s2_v_ff) begin
         if (!s2_use_ff) begin
            push_n = fresh ? 2'd1 : 2'd0;
         end else if (!fresh) begin
            if (sd_live) begin
               push_n = 2'd1;
               push_a = shd_pt;
            end
            wr_en = expired;
         end else if (near) begin
            push_n      = 2'd2;
            push_a.last = 1'b0;
         end else begin
            push_n = 2'd1;
            wr_en  = 1'b1;
            wdata  = '{depth: s2_depth_ff, stamp: s2_now_ff, x: cur_x, y: cur_y,
                       rgb: (s2_rgb_ff >> 1) & 24'h7F7F7F};
         end
      end
   end

   // last write, registered for forwarding in the next cycle
   always_ff @(posedge clock) begin
      if (reset) lw_v_ff <= 1'b0;
      else       lw_v_ff <= wr_en;
      lw_addr_ff <= s2_addr_ff;
      lw_data_ff <= wdata;
   end

   dcos_store #(.SIZE(SIZE), .AW(AW)) u_store (
      .clock     (clock),
      .reset     (reset),
      .clear_req (clear_req),
      .clearing  (clearing),
      .rd_addr   (addr_full[AW-1:0]),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (s2_addr_ff),
      .wr_data   (wdata)
   );

   point_type head;

   dcos_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_a    (push_a),
      .push_b    (push_b),
      .count     (q_count),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_x_mm        = head.x;
   assign rsp_y_mm        = head.y;
   assign rsp_z_mm        = head.z;
   assign rsp_point_color = head.color;
   assign rsp_is_shadow   = head.is_shadow;
   assign rsp_last        = head.last;

endmodule
